[src/array_set_membership_defines.svh]
// Assertion macros shared by the array set checker.
`ifndef ARRAY_SET_MEMBERSHIP_DEFINES_SVH
`define ARRAY_SET_MEMBERSHIP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[src/asm_pkg.sv]
// Package for the array set: sizes, codes and item types.
package asm_pkg;

    localparam int CAPACITY   = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int COUNT_W    = 7;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [1:0] ST_TRUE  = 2'd0;
    localparam logic [1:0] ST_FALSE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] elem;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
    } t_out_item;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [ELEM_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

endpackage

[src/asm_ram.sv]
// Simple dual-port RAM: one write and one registered read per cycle.
module asm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/asm_ctrl.sv]
// Sequencer: scans the entry store, appends on add, compacts on remove.
module asm_ctrl import asm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_out_item             o_res_item,
    output t_mem_req              o_mem,
    input  logic [ELEM_WIDTH-1:0] i_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state                r_state,     n_state;
    logic [1:0]            r_action,    n_action;
    logic [ELEM_WIDTH-1:0] r_elem,      n_elem;
    logic [CNT_W-1:0]      r_count,     n_count;
    logic [CNT_W-1:0]      r_idx,       n_idx;
    logic                  r_pend,      n_pend;
    logic [ADDR_W-1:0]     r_pend_addr, n_pend_addr;
    logic [1:0]            r_status,    n_status;
    logic                  issue;
    logic                  hit;

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_elem      = r_elem;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_addr = r_idx[ADDR_W-1:0];
        n_status    = r_status;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_count[ADDR_W-1:0];
        o_mem.wdata = r_elem;
        o_mem.raddr = r_idx[ADDR_W-1:0];
        issue       = 1'b0;
        hit         = r_pend && (i_rd_data == r_elem);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_in_item.action;
                    n_elem   = ELEM_WIDTH'(i_in_item.elem);
                    n_idx    = '0;
                    case (i_in_item.action)
                        ACT_ADD, ACT_REMOVE, ACT_SEARCH: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_status = ST_FALSE;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read one entry a cycle, compare it the cycle after
                issue  = r_idx < r_count;
                n_pend = issue;
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (hit) begin
                    n_pend = 1'b0;
                    case (r_action)
                        ACT_ADD: begin
                            n_status = ST_FALSE;
                            n_state  = S_RESP;
                        end
                        ACT_REMOVE: begin
                            n_idx   = CNT_W'(r_pend_addr) + 1'b1;
                            n_state = S_SHIFT;
                        end
                        default: begin
                            n_status = ST_TRUE;
                            n_state  = S_RESP;
                        end
                    endcase
                end else if (!issue && !r_pend) begin
                    n_state = S_RESP;
                    case (r_action)
                        ACT_ADD: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem.we = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_status = ST_TRUE;
                            end
                        end
                        default: begin
                            n_status = ST_FALSE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // entry i+1 read this cycle lands at i next cycle
                issue  = r_idx < r_count;
                n_pend = issue;
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_pend_addr - 1'b1;
                    o_mem.wdata = i_rd_data;
                end
                if (!issue && !r_pend) begin
                    n_count  = r_count - 1'b1;
                    n_status = ST_TRUE;
                    n_state  = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_elem      <= n_elem;
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        r_status    <= n_status;
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_RESP);
    assign o_res_item.status    = r_status;
    assign o_res_item.count     = COUNT_W'(r_count);
    assign o_res_item.empty_res = (r_count == '0);

endmodule

[src/array_set_membership.sv]
// Array set top level: input channel, sequencer, entry RAM, output register.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one item: action (add,
//   remove, search) and elem. Output channel o_out_valid / i_out_ready
//   returns exactly one item per input: status, count after the
//   operation and empty_res.
// Timing:
//   The sequencer reads the entry RAM one entry per cycle and compares each
//   read in the cycle after. A remove that hits moves every later entry
//   down one place. The result goes from the response state into the output
//   register; it shows on o_out_valid in the same cycle as the next item can
//   be accepted.
// Reset:
//   Clears the element count and control state; RAM contents are left as
//   they are, since entries at or above the count are never read.
// Stall:
//   A result waits in the output register; the sequencer takes and works on
//   the next item and holds its own result until the register empties.
module array_set_membership import asm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_mem_req              mem_req;
    logic [ELEM_WIDTH-1:0] rd_data;
    logic                  res_valid;
    logic                  res_ready;
    t_out_item             res_item;

    logic                  r_out_valid;
    t_out_item             r_out_item;

    asm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_item  (res_item),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    // entry store; no reset needed, only entries below the count are read
    asm_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEM_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    // output register decouples the sequencer from a stalled receiver
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_item <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[src/asm_checker.sv]
// Port-level checker for the array set, bound to the top level.
`include "array_set_membership_defines.svh"

module asm_checker import asm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    `ASM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))
    `ASM_ASSERT_IMP(a_empty_match, i_clk, i_rst_n, o_out_valid, o_out_item.empty_res == (o_out_item.count == '0))
    `ASM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, o_out_valid, o_out_item.count <= COUNT_W'(CAPACITY))
    `ASM_ASSERT_IMP(a_full_at_cap, i_clk, i_rst_n, o_out_valid && (o_out_item.status == ST_FULL), o_out_item.count == COUNT_W'(CAPACITY))

endmodule

bind array_set_membership asm_checker u_asm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
